// File: hw/rtl/motion_command_queue_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motion command queue sequencer
// Checks are clocked on clk and are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOTION_COMMAND_QUEUE_SEQUENCER_ASSERT_SVH
`define MOTION_COMMAND_QUEUE_SEQUENCER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MCQS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MCQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mcqs_pkg.sv
// ----------------------------------------------------------------------------
// mcqs_pkg
// Shared constants, types and helpers of the motion command queue sequencer.
// ----------------------------------------------------------------------------
package mcqs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int TYPE_W      = 4;
	localparam int TARGET_W    = 16;
	localparam int TIMER_W     = 16;
	localparam int COUNT_W     = 4;
	localparam int ENTRY_W     = TYPE_W + 2 * TARGET_W;
	localparam int CNT_WIDE_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RESET = 2'd2
	} cmd_t;

	localparam logic [TYPE_W-1:0] TYPE_IDLE  = 4'd0;
	localparam logic [TYPE_W-1:0] TYPE_SPEED = 4'd1;
	localparam logic [TYPE_W-1:0] TYPE_WAIT  = 4'd2;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [TYPE_W-1:0]          kind;
		logic signed [TARGET_W-1:0] left;
		logic signed [TARGET_W-1:0] right;
	} entry_t;

	function automatic idx_t next_idx(input idx_t i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

endpackage

// File: hw/rtl/motion_command_queue_sequencer.sv
// ----------------------------------------------------------------------------
// motion_command_queue_sequencer
// Ring buffer of motion entries drained one entry per idle tick, with a dwell
// timer for wait entries and a speed request for set-speed entries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The head entry is
// read from the entry RAM in that cycle; in the next cycle the read data is
// back, the queue state is updated and the result registers load; done is
// high in the following cycle for exactly one cycle and the receiver cannot
// stall it. Each request gives exactly one result. A new request can be taken
// in the cycle done is high, but not while busy is high and the block is still
// executing the last request. queue_running and queue_count show the state
// after the request while done is high.
module motion_command_queue_sequencer
	import mcqs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic [15:0]                elapsed_ms,
	input  logic                       mover_busy,
	input  logic [3:0]                 motion_type,
	input  logic signed [15:0]         left_target,
	input  logic signed [15:0]         right_target,
	output logic                       done,
	output logic                       issue_valid,
	output logic [3:0]                 issue_type,
	output logic signed [15:0]         issue_left,
	output logic signed [15:0]         issue_right,
	output logic                       speed_valid,
	output logic                       high_speed,
	output logic                       queue_running,
	output logic [3:0]                 queue_count,
	output logic                       add_dropped
);

	state_t state_q, state_d;
	logic   accept;
	logic   exec;

	// captured request
	logic [1:0]          cmd_q;
	logic [TIMER_W-1:0]  elapsed_q;
	logic                mover_busy_q;
	entry_t              new_entry_q;

	// queue state
	idx_t               head_q, head_d;
	idx_t               tail_q, tail_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic               running_q, running_d;

	// result registers
	logic                       done_q;
	logic                       issue_valid_q, issue_valid_d;
	logic [TYPE_W-1:0]          issue_type_q, issue_type_d;
	logic signed [TARGET_W-1:0] issue_left_q, issue_left_d;
	logic signed [TARGET_W-1:0] issue_right_q, issue_right_d;
	logic                       speed_valid_q, speed_valid_d;
	logic                       high_speed_q, high_speed_d;
	logic                       dropped_q, dropped_d;

	// entry RAM
	logic                 wr_en;
	logic [ENTRY_W-1:0]   rd_data;
	entry_t               head_entry;

	logic [TIMER_W-1:0] timer_dec;
	logic               queue_empty;
	logic               queue_full;
	idx_t               tail_next;
	logic [IDX_W:0]     cnt_full;
	logic [CNT_WIDE_W-1:0] cnt_wide;

	mcqs_ram #(
		.DEPTH (QUEUE_DEPTH),
		.DATA_W(ENTRY_W)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(new_entry_q),
		.rd_en  (accept),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	assign head_entry = entry_t'(rd_data);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	assign timer_dec   = (timer_q > elapsed_q) ? TIMER_W'(timer_q - elapsed_q) : '0;
	assign queue_empty = (head_q == tail_q);
	assign tail_next   = next_idx(tail_q);
	assign queue_full  = (tail_next == head_q);

	// read-modify-write of the queue state
	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		timer_d       = timer_q;
		running_d     = running_q;
		wr_en         = 1'b0;
		issue_valid_d = 1'b0;
		issue_type_d  = TYPE_IDLE;
		issue_left_d  = '0;
		issue_right_d = '0;
		speed_valid_d = 1'b0;
		high_speed_d  = 1'b0;
		dropped_d     = 1'b0;
		if (exec) begin
			unique case (cmd_q)
				CMD_TICK: begin
					timer_d = timer_dec;
					if (timer_dec == '0 && !mover_busy_q) begin
						if (!queue_empty) begin
							case (head_entry.kind)
								TYPE_SPEED: begin
									speed_valid_d = 1'b1;
									high_speed_d  = (head_entry.left != '0);
								end
								// negative wait loads zero
								TYPE_WAIT: timer_d = head_entry.left[TARGET_W-1] ?
									'0 : TIMER_W'(head_entry.left);
								default: begin
									running_d     = 1'b1;
									issue_valid_d = 1'b1;
									issue_type_d  = head_entry.kind;
									issue_left_d  = head_entry.left;
									issue_right_d = head_entry.right;
								end
							endcase
							head_d = next_idx(head_q);
						end else begin
							running_d = 1'b0;
						end
					end
				end
				CMD_ADD: begin
					if (queue_full) begin
						dropped_d = 1'b1;
					end else begin
						wr_en  = 1'b1;
						tail_d = tail_next;
					end
				end
				CMD_RESET: begin
					head_d        = tail_q;
					issue_valid_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			timer_q   <= '0;
			running_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			timer_q   <= timer_d;
			running_q <= running_d;
			done_q    <= exec;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= command;
			elapsed_q    <= elapsed_ms;
			mover_busy_q <= mover_busy;
			new_entry_q  <= '{kind: motion_type, left: left_target, right: right_target};
		end
		if (exec) begin
			issue_valid_q <= issue_valid_d;
			issue_type_q  <= issue_type_d;
			issue_left_q  <= issue_left_d;
			issue_right_q <= issue_right_d;
			speed_valid_q <= speed_valid_d;
			high_speed_q  <= high_speed_d;
			dropped_q     <= dropped_d;
		end
	end

	// waiting entries, wrapped around the ring
	assign cnt_full = (tail_q >= head_q) ?
		(IDX_W+1)'({1'b0, tail_q} - {1'b0, head_q}) :
		(IDX_W+1)'({1'b0, tail_q} + (IDX_W+1)'(QUEUE_DEPTH) - {1'b0, head_q});
	assign cnt_wide = CNT_WIDE_W'(cnt_full[IDX_W-1:0]);

	assign done          = done_q;
	assign issue_valid   = issue_valid_q;
	assign issue_type    = issue_type_q;
	assign issue_left    = issue_left_q;
	assign issue_right   = issue_right_q;
	assign speed_valid   = speed_valid_q;
	assign high_speed    = high_speed_q;
	assign queue_running = running_q;
	assign queue_count   = cnt_wide[COUNT_W-1:0];
	assign add_dropped   = dropped_q;

`include "motion_command_queue_sequencer_assert.svh"

	`MCQS_ASSERT_NEXT(a_accept_goes_busy, accept, busy && exec, "accepted request did not start")
	`MCQS_ASSERT_NEXT(a_done_after_exec, exec, done && !busy, "result strobe did not follow execution")
	`MCQS_ASSERT_SAME(a_one_kind_of_result, done, !(issue_valid && speed_valid), "move and speed request in one result")
	`MCQS_ASSERT_SAME(a_drop_only_when_full, done && add_dropped, cnt_full == (IDX_W+1)'(QUEUE_DEPTH - 1), "add refused with room left")
	`MCQS_ASSERT_SAME(a_indices_in_range, 1'b1, (IDX_W+1)'(head_q) < (IDX_W+1)'(QUEUE_DEPTH) && (IDX_W+1)'(tail_q) < (IDX_W+1)'(QUEUE_DEPTH), "queue index beyond depth")

endmodule

// File: hw/rtl/mcqs_ram.sv
// ----------------------------------------------------------------------------
// mcqs_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mcqs_ram #(
	parameter int DEPTH = 16,
	parameter int DATA_W = 36,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: tb/motion_command_queue_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion command queue sequencer checker
// Follows every accepted request through its own model of the ring buffer,
// the dwell timer and the running flag, queues the predicted result and
// compares each done cycle of the block against the oldest prediction.
// ----------------------------------------------------------------------------
module motion_command_queue_sequencer_checker
	import mcqs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          command,
	input  logic [15:0]         elapsed_ms,
	input  logic                mover_busy,
	input  logic [3:0]          motion_type,
	input  logic signed [15:0]  left_target,
	input  logic signed [15:0]  right_target,
	input  logic                done,
	input  logic                issue_valid,
	input  logic [3:0]          issue_type,
	input  logic signed [15:0]  issue_left,
	input  logic signed [15:0]  issue_right,
	input  logic                speed_valid,
	input  logic                high_speed,
	input  logic                queue_running,
	input  logic [3:0]          queue_count,
	input  logic                add_dropped,
	output int                  fail_count,
	output int                  outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                       issue_valid;
		logic [TYPE_W-1:0]          issue_type;
		logic signed [TARGET_W-1:0] issue_left;
		logic signed [TARGET_W-1:0] issue_right;
		logic                       speed_valid;
		logic                       high_speed;
		logic                       queue_running;
		logic [COUNT_W-1:0]         queue_count;
		logic                       add_dropped;
	} sequencer_result_t;

	entry_t             slot_mem [QUEUE_DEPTH];
	idx_t               head_q;
	idx_t               tail_q;
	logic [TIMER_W-1:0] dwell_q;
	logic               running_q;
	sequencer_result_t  expected_results [$];

	function automatic idx_t advance_idx(input idx_t i);
		return idx_t'((int'(i) + 1) % QUEUE_DEPTH);
	endfunction

	function automatic string describe(input sequencer_result_t r);
		return $sformatf("issue=%0d type=%0d left=%0d right=%0d speed=%0d high=%0d run=%0d cnt=%0d drop=%0d",
			r.issue_valid, r.issue_type, r.issue_left, r.issue_right, r.speed_valid,
			r.high_speed, r.queue_running, r.queue_count, r.add_dropped);
	endfunction

	// Apply one request to the model state and return the result it gives.
	function automatic sequencer_result_t predict_step(input logic [1:0] cmd,
			input logic [15:0] elapsed, input logic mbusy, input logic [3:0] mtype,
			input logic signed [15:0] left, input logic signed [15:0] right);
		sequencer_result_t r;
		entry_t            e;
		idx_t              nt;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (dwell_q > elapsed)
					dwell_q = dwell_q - elapsed;
				else
					dwell_q = '0;
				if (dwell_q == '0 && !mbusy) begin
					if (head_q != tail_q) begin
						e = slot_mem[head_q];
						if (e.kind == TYPE_SPEED) begin
							r.speed_valid = 1'b1;
							r.high_speed  = (e.left != 16'sd0);
						end else if (e.kind == TYPE_WAIT) begin
							// negative waits load zero
							dwell_q = ($signed(e.left) > 16'sd0) ? e.left : '0;
						end else begin
							running_q     = 1'b1;
							r.issue_valid = 1'b1;
							r.issue_type  = e.kind;
							r.issue_left  = e.left;
							r.issue_right = e.right;
						end
						head_q = advance_idx(head_q);
					end else begin
						running_q = 1'b0;
					end
				end
			end
			CMD_ADD: begin
				nt = advance_idx(tail_q);
				if (nt == head_q) begin
					r.add_dropped = 1'b1;
				end else begin
					slot_mem[tail_q] = '{kind: mtype, left: left, right: right};
					tail_q = nt;
				end
			end
			CMD_RESET: begin
				head_q        = tail_q;
				r.issue_valid = 1'b1;
			end
			default: ;
		endcase
		r.queue_running = running_q;
		r.queue_count   = COUNT_W'((int'(tail_q) + QUEUE_DEPTH - int'(head_q)) % QUEUE_DEPTH);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		sequencer_result_t observed;
		sequencer_result_t predicted;
		if (!arst_n) begin
			head_q      = '0;
			tail_q      = '0;
			dwell_q     = '0;
			running_q   = 1'b0;
			fail_count  = 0;
			outstanding = 0;
			expected_results.delete();
		end else begin
			// compare before predicting: a result always belongs to an older request
			if (done === 1'b1) begin
				observed = '{issue_valid, issue_type, issue_left, issue_right, speed_valid,
					high_speed, queue_running, queue_count, add_dropped};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with no request pending: %s", $realtime,
							describe(observed));
				end else begin
					predicted = expected_results.pop_front();
					if (observed !== predicted) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", describe(predicted));
							$display("  actual   %s", describe(observed));
						end
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_step(command, elapsed_ms, mover_busy,
					motion_type, left_target, right_target));
			outstanding = expected_results.size();
		end
	end

endmodule

// File: tb/tb_motion_command_queue_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the motion command queue sequencer
// Drives a directed pass over the special entries and the timer, then random
// bursts of adds, ticks, resets and noise with random sender gaps; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_motion_command_queue_sequencer;
	import mcqs_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam int         RANDOM_ITEMS  = 1400;
	localparam int         CALM_ITEMS    = 200;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam int         DRAIN_CYCLES  = 8;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic [15:0]        elapsed_ms;
	logic               mover_busy;
	logic [3:0]         motion_type;
	logic signed [15:0] left_target;
	logic signed [15:0] right_target;
	logic               done;
	logic               issue_valid;
	logic [3:0]         issue_type;
	logic signed [15:0] issue_left;
	logic signed [15:0] issue_right;
	logic               speed_valid;
	logic               high_speed;
	logic               queue_running;
	logic [3:0]         queue_count;
	logic               add_dropped;

	int fail_count;
	int outstanding;
	int sent_items;
	int idle_cycles;

	motion_command_queue_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.elapsed_ms    (elapsed_ms),
		.mover_busy    (mover_busy),
		.motion_type   (motion_type),
		.left_target   (left_target),
		.right_target  (right_target),
		.done          (done),
		.issue_valid   (issue_valid),
		.issue_type    (issue_type),
		.issue_left    (issue_left),
		.issue_right   (issue_right),
		.speed_valid   (speed_valid),
		.high_speed    (high_speed),
		.queue_running (queue_running),
		.queue_count   (queue_count),
		.add_dropped   (add_dropped)
	);

	motion_command_queue_sequencer_checker sequence_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.elapsed_ms    (elapsed_ms),
		.mover_busy    (mover_busy),
		.motion_type   (motion_type),
		.left_target   (left_target),
		.right_target  (right_target),
		.done          (done),
		.issue_valid   (issue_valid),
		.issue_type    (issue_type),
		.issue_left    (issue_left),
		.issue_right   (issue_right),
		.speed_valid   (speed_valid),
		.high_speed    (high_speed),
		.queue_running (queue_running),
		.queue_count   (queue_count),
		.add_dropped   (add_dropped),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic [1:0] cmd, input logic [15:0] elapsed,
			input logic mbusy, input logic [3:0] mtype, input logic [15:0] left,
			input logic [15:0] right);
		@(negedge clk);
		start        <= 1'b1;
		command      <= cmd;
		elapsed_ms   <= elapsed;
		mover_busy   <= mbusy;
		motion_type  <= mtype;
		left_target  <= left;
		right_target <= right;
		do @(posedge clk); while (busy);
		sent_items++;
	endtask

	task automatic pause_requests(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic idle_gap(input logic calm);
		if (!calm && $urandom_range(0, 4) == 0)
			pause_requests($urandom_range(1, 14));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic send_entry();
		logic [3:0]  mtype;
		logic [15:0] left;
		int          pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       mtype = TYPE_IDLE;
			1:       mtype = TYPE_SPEED;
			2, 3:    mtype = TYPE_WAIT;
			default: mtype = 4'($urandom_range(3, 15));
		endcase
		left = 16'($urandom());
		if (mtype == TYPE_WAIT) begin
			// keep most waits short so the queue keeps moving
			pick = $urandom_range(0, 9);
			if (pick < 7)
				left = 16'($urandom_range(0, 25));
			else if (pick == 7)
				left = 16'(-$urandom_range(1, 100));
		end else if (mtype == TYPE_SPEED && $urandom_range(0, 1) == 0) begin
			left = '0;
		end
		send_request(CMD_ADD, 16'($urandom()), 1'($urandom_range(0, 1)), mtype, left,
			16'($urandom()));
	endtask

	task automatic send_tick();
		logic [15:0] elapsed;
		elapsed = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
		send_request(CMD_TICK, elapsed, $urandom_range(0, 4) == 0, 4'($urandom()),
			16'($urandom()), 16'($urandom()));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int   pick;
		int   burst;
		int   random_goal;
		logic calm;
		start        = 1'b0;
		command      = CMD_TICK;
		elapsed_ms   = '0;
		mover_busy   = 1'b0;
		motion_type  = TYPE_IDLE;
		left_target  = '0;
		right_target = '0;
		sent_items   = 0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty queue, unused code, every entry kind, timer edges
		send_request(CMD_TICK, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_UNUSED, 16'hFFFF, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF);
		send_request(CMD_RESET, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_IDLE, 16'h8000, 16'h7FFF);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_SPEED, 16'h0000, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_SPEED, 16'hFFFF, 16'hFFFF);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_WAIT, 16'hFFFB, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_WAIT, 16'h0003, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, 4'd15, 16'h7FFF, 16'h8000);
		send_request(CMD_TICK, 16'h0000, 1'b1, TYPE_IDLE, 16'h0000, 16'h0000);
		repeat (5) send_request(CMD_TICK, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0001, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'hFFFF, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, TYPE_WAIT, 16'h7FFF, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'hFFFF, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_ADD, 16'h0000, 1'b0, 4'd5, 16'd100, 16'd200);
		send_request(CMD_RESET, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		send_request(CMD_TICK, 16'h0000, 1'b0, TYPE_IDLE, 16'h0000, 16'h0000);
		wait_all_results();

		// random: bursts long enough to overfill the queue, then drain it
		random_goal = sent_items + RANDOM_ITEMS;
		while (sent_items < random_goal) begin
			calm = (random_goal - sent_items) <= CALM_ITEMS;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				burst = $urandom_range(1, 18);
				repeat (burst) begin
					idle_gap(calm);
					send_entry();
				end
			end else if (pick < 87) begin
				burst = $urandom_range(1, 20);
				repeat (burst) begin
					idle_gap(calm);
					send_tick();
				end
			end else if (pick < 94) begin
				idle_gap(calm);
				send_request(2'($urandom_range(0, 3)), 16'($urandom()),
					1'($urandom_range(0, 1)), 4'($urandom()), 16'($urandom()),
					16'($urandom()));
			end else if (pick < 97) begin
				idle_gap(calm);
				send_request(CMD_RESET, 16'($urandom()), 1'($urandom_range(0, 1)),
					4'($urandom()), 16'($urandom()), 16'($urandom()));
			end else if (!calm) begin
				wait_all_results();
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mcqs_pkg.sv
hw/rtl/mcqs_ram.sv
hw/rtl/motion_command_queue_sequencer.sv
tb/motion_command_queue_sequencer_checker.sv
tb/tb_motion_command_queue_sequencer.sv
